// ----- src/tsv_pkg.sv -----
// Shared constants and codes of the tensor slice view descriptor.
`timescale 1ns / 1ps

package tsv_pkg;

   localparam int SIZE_BITS_DEF   = 32;
   localparam int STRIDE_BITS_DEF = 40;
   localparam int OFFSET_BITS_DEF = 48;

   // Entries of the queue between the classifier and the arithmetic unit.
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_ZERO_STEP = 3'd1,
      ERR_BOUNDS    = 3'd2,
      ERR_ORDER     = 3'd3,
      ERR_OVERFLOW  = 3'd4
   } err_code_type;

endpackage

// ----- src/tsv_front.sv -----
// Front end: accepts a dimension word, resolves slice defaults and wrapping, and classifies it.
`timescale 1ns / 1ps

module tsv_front #(
   parameter int SIZE_BITS   = tsv_pkg::SIZE_BITS_DEF,
   parameter int STRIDE_BITS = tsv_pkg::STRIDE_BITS_DEF,
   parameter int OFFSET_BITS = tsv_pkg::OFFSET_BITS_DEF,
   parameter type job_type   = logic
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic                   first_dim,
   input  logic                   last_dim,
   input  logic [OFFSET_BITS-1:0] base_offset,
   input  logic [SIZE_BITS-1:0]   dim_size,
   input  logic [STRIDE_BITS-1:0] dim_stride,
   input  logic                   has_slice,
   input  logic                   start_given,
   input  logic [SIZE_BITS:0]     start_index,
   input  logic                   end_given,
   input  logic [SIZE_BITS:0]     end_index,
   input  logic                   step_given,
   input  logic [SIZE_BITS:0]     step_value,
   output job_type                job_out,
   output logic                   job_valid,
   input  logic                   job_ready
);
   import tsv_pkg::*;

   localparam int IB = SIZE_BITS + 1;
   localparam int CW = SIZE_BITS + 2;

   logic                   valid_ff, valid_in;
   logic                   first_ff, first_in;
   logic                   last_ff, last_in;
   logic                   pass_ff, pass_in;
   logic [OFFSET_BITS-1:0] base_ff, base_in;
   logic [SIZE_BITS-1:0]   dim_ff, dim_in;
   logic [STRIDE_BITS-1:0] stride_ff, stride_in;
   logic signed [CW-1:0]   start_ff, start_in;
   logic signed [CW-1:0]   end_ff, end_in;
   logic [IB-1:0]          step_ff, step_in;

   logic                   accept;
   logic signed [CW-1:0]   dim_in_s;
   logic signed [CW-1:0]   start_raw;
   logic signed [CW-1:0]   end_raw;
   logic [IB-1:0]          step_raw;

   logic signed [CW-1:0]   dim_s;
   logic                   step_neg;
   logic                   step_zero;
   logic                   out_bounds;
   logic                   bad_order;
   logic signed [CW-1:0]   diff_fwd;
   logic signed [CW-1:0]   diff_bwd;
   logic                   stride_neg;
   logic [STRIDE_BITS-1:0] stride_mag;
   logic [IB-1:0]          step_mag;

   assign in_ready  = !valid_ff || job_ready;
   assign accept    = in_valid && in_ready;
   assign job_valid = valid_ff;

   // Defaults are filled in and negative indices are wrapped as the word is taken.
   always_comb begin
      dim_in_s  = $signed({2'b00, dim_size});
      start_raw = start_given ? $signed({start_index[IB-1], start_index}) : '0;
      end_raw   = end_given ? $signed({end_index[IB-1], end_index}) : dim_in_s;
      step_raw  = step_given ? step_value : {{(IB-1){1'b0}}, 1'b1};

      valid_in  = accept ? 1'b1 : (job_ready ? 1'b0 : valid_ff);
      first_in  = accept ? first_dim : first_ff;
      last_in   = accept ? last_dim : last_ff;
      pass_in   = accept ? !has_slice : pass_ff;
      base_in   = accept ? base_offset : base_ff;
      dim_in    = accept ? dim_size : dim_ff;
      stride_in = accept ? dim_stride : stride_ff;
      step_in   = accept ? step_raw : step_ff;
      start_in  = start_ff;
      end_in    = end_ff;
      if (accept) begin
         start_in = start_raw[CW-1] ? start_raw + dim_in_s : start_raw;
         end_in   = end_raw[CW-1] ? end_raw + dim_in_s : end_raw;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff  <= first_in;
      last_ff   <= last_in;
      pass_ff   <= pass_in;
      base_ff   <= base_in;
      dim_ff    <= dim_in;
      stride_ff <= stride_in;
      start_ff  <= start_in;
      end_ff    <= end_in;
      step_ff   <= step_in;
   end

   // Classification of the held word.
   always_comb begin
      dim_s      = $signed({2'b00, dim_ff});
      step_neg   = step_ff[IB-1];
      step_zero  = (step_ff == '0);
      out_bounds = start_ff[CW-1] || (start_ff > dim_s) || end_ff[CW-1] || (end_ff > dim_s);
      bad_order  = !step_neg && (start_ff > end_ff);
      diff_fwd   = end_ff - start_ff;
      diff_bwd   = start_ff - end_ff;
      stride_neg = stride_ff[STRIDE_BITS-1];
      stride_mag = stride_neg ? (~stride_ff + 1'b1) : stride_ff;
      step_mag   = step_neg ? (~step_ff + 1'b1) : step_ff;

      job_out.first = first_ff;
      job_out.last  = last_ff;
      job_out.base  = base_ff;
      job_out.sneg  = stride_neg;
      job_out.smag  = stride_mag;

      if (pass_ff) begin
         // An unsliced dimension runs as a step of one from index zero over the full size.
         job_out.err     = ERR_NONE;
         job_out.pneg    = stride_neg;
         job_out.stepmag = {{(IB-1){1'b0}}, 1'b1};
         job_out.st      = '0;
         job_out.span    = dim_ff;
      end else begin
         if (step_zero) begin
            job_out.err = ERR_ZERO_STEP;
         end else if (out_bounds) begin
            job_out.err = ERR_BOUNDS;
         end else if (bad_order) begin
            job_out.err = ERR_ORDER;
         end else begin
            job_out.err = ERR_NONE;
         end
         job_out.pneg    = stride_neg ^ step_neg;
         job_out.stepmag = step_mag;
         job_out.st      = start_ff[SIZE_BITS-1:0];
         if (step_neg) begin
            job_out.span = (start_ff > end_ff) ? diff_bwd[SIZE_BITS-1:0] : '0;
         end else begin
            job_out.span = (start_ff < end_ff) ? diff_fwd[SIZE_BITS-1:0] : '0;
         end
      end
   end

endmodule

// ----- src/tsv_queue.sv -----
// Short queue of classified dimensions between the front end and the arithmetic unit.
`timescale 1ns / 1ps

module tsv_queue #(
   parameter type job_type = logic
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  job_type in_job,
   output logic    out_valid,
   input  logic    out_ready,
   output job_type out_job
);
   import tsv_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push;
   logic               pop;

   assign in_ready  = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_job   = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_job;
      end
   end

endmodule

// ----- src/tsv_back.sv -----
// Back end: serial multiply with overflow checks, serial ceiling divide, and the view offset.
`timescale 1ns / 1ps

module tsv_back #(
   parameter int SIZE_BITS   = tsv_pkg::SIZE_BITS_DEF,
   parameter int STRIDE_BITS = tsv_pkg::STRIDE_BITS_DEF,
   parameter int OFFSET_BITS = tsv_pkg::OFFSET_BITS_DEF,
   parameter type job_type   = logic
) (
   input  logic                    clock,
   input  logic                    reset,
   input  job_type                 job_in,
   input  logic                    job_valid,
   output logic                    job_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [SIZE_BITS-1:0]    new_size,
   output logic [STRIDE_BITS-1:0]  view_stride,
   output logic [OFFSET_BITS-1:0]  view_offset,
   output tsv_pkg::err_code_type   error_code,
   output logic                    view_failed,
   output logic                    is_last
);
   import tsv_pkg::*;

   localparam int IB    = SIZE_BITS + 1;
   localparam int CNT_W = $clog2(IB);
   localparam int WIDE  = (OFFSET_BITS > STRIDE_BITS) ? OFFSET_BITS : STRIDE_BITS;
   localparam int DW    = WIDE + 2;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_FIN  = 3'b100
   } state_type;

   state_type              state_ff, state_in;
   job_type                job_ff, job_reg_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [IB-1:0]          pbits_ff, pbits_in;
   logic [IB-1:0]          dbits_ff, dbits_in;
   logic [STRIDE_BITS:0]   pacc_ff, pacc_in;
   logic [DW-1:0]          dacc_ff, dacc_in;
   logic                   povf_ff, povf_in;
   logic                   dovf_ff, dovf_in;
   logic [IB-1:0]          num_ff, num_in;
   logic [SIZE_BITS-1:0]   rem_ff, rem_in;
   logic [IB-1:0]          quo_ff, quo_in;
   logic [STRIDE_BITS-1:0] lim_ff, lim_in;
   logic [OFFSET_BITS-1:0] room_ff, room_in;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;
   logic                   seen_ff, seen_in;

   logic                   out_valid_ff, out_valid_in;
   logic [SIZE_BITS-1:0]   out_size_ff, out_size_in;
   logic [STRIDE_BITS-1:0] out_stride_ff, out_stride_in;
   logic [OFFSET_BITS-1:0] out_offset_ff, out_offset_in;
   err_code_type           out_err_ff, out_err_in;
   logic                   out_failed_ff, out_failed_in;
   logic                   out_last_ff, out_last_in;

   logic                   out_free;
   logic [OFFSET_BITS-1:0] off_cur;
   logic [STRIDE_BITS:0]   pacc_step;
   logic [DW-1:0]          dacc_step;
   logic [IB-1:0]          div_trial;
   logic                   div_ge;
   err_code_type           err_final;
   logic                   fin_ok;
   logic [SIZE_BITS-1:0]   len;
   logic [STRIDE_BITS-1:0] prod_mag;
   logic [STRIDE_BITS-1:0] stride_res;
   logic [OFFSET_BITS-1:0] delta;
   logic [OFFSET_BITS-1:0] offset_res;

   assign job_ready   = (state_ff == ST_IDLE);
   assign out_free    = !out_valid_ff || rsp_ready;
   assign rsp_valid   = out_valid_ff;
   assign new_size    = out_size_ff;
   assign view_stride = out_stride_ff;
   assign view_offset = out_offset_ff;
   assign error_code  = out_err_ff;
   assign view_failed = out_failed_ff;
   assign is_last     = out_last_ff;

   always_comb begin
      off_cur = job_in.first ? job_in.base : offset_ff;

      // Shift-and-add step: both products grow by one multiplier bit, MSB first.
      // Each stays monotonic, so once it passes its limit the overflow flag is final.
      pacc_step = {pacc_ff[STRIDE_BITS-1:0], 1'b0}
                + (pbits_ff[IB-1] ? {1'b0, job_ff.smag} : '0);
      dacc_step = {dacc_ff[DW-2:0], 1'b0}
                + (dbits_ff[IB-1] ? {{(DW-STRIDE_BITS){1'b0}}, job_ff.smag} : '0);

      // Restoring divide step; the remainder always stays below the divisor.
      div_trial = {rem_ff, num_ff[IB-1]};
      div_ge    = (div_trial >= job_ff.stepmag);

      if (job_ff.err != ERR_NONE) begin
         err_final = job_ff.err;
      end else if (povf_ff || dovf_ff) begin
         err_final = ERR_OVERFLOW;
      end else begin
         err_final = ERR_NONE;
      end
      fin_ok     = (err_final == ERR_NONE);
      len        = quo_ff[SIZE_BITS-1:0] + SIZE_BITS'(rem_ff != '0);
      prod_mag   = pacc_ff[STRIDE_BITS-1:0];
      stride_res = job_ff.pneg ? (~prod_mag + 1'b1) : prod_mag;
      delta      = dacc_ff[OFFSET_BITS-1:0];
      offset_res = job_ff.sneg ? (offset_ff - delta) : (offset_ff + delta);

      state_in   = state_ff;
      job_reg_in = job_ff;
      cnt_in     = cnt_ff;
      pbits_in   = pbits_ff;
      dbits_in   = dbits_ff;
      pacc_in    = pacc_ff;
      dacc_in    = dacc_ff;
      povf_in    = povf_ff;
      dovf_in    = dovf_ff;
      num_in     = num_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      lim_in     = lim_ff;
      room_in    = room_ff;
      offset_in  = offset_ff;
      seen_in    = seen_ff;

      out_valid_in  = rsp_ready ? 1'b0 : out_valid_ff;
      out_size_in   = out_size_ff;
      out_stride_in = out_stride_ff;
      out_offset_in = out_offset_ff;
      out_err_in    = out_err_ff;
      out_failed_in = out_failed_ff;
      out_last_in   = out_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_reg_in = job_in;
               cnt_in     = CNT_W'(IB - 1);
               pbits_in   = job_in.stepmag;
               dbits_in   = {1'b0, job_in.st};
               pacc_in    = '0;
               dacc_in    = '0;
               povf_in    = 1'b0;
               dovf_in    = 1'b0;
               num_in     = {1'b0, job_in.span};
               rem_in     = '0;
               quo_in     = '0;
               lim_in     = job_in.pneg ? {1'b1, {(STRIDE_BITS-1){1'b0}}}
                                        : {1'b0, {(STRIDE_BITS-1){1'b1}}};
               // Headroom toward the end of the offset range that the stride's sign moves to.
               room_in    = job_in.sneg ? off_cur : ~off_cur;
               if (job_in.first) begin
                  offset_in = job_in.base;
                  seen_in   = 1'b0;
               end
               state_in   = (job_in.err != ERR_NONE) ? ST_FIN : ST_RUN;
            end
         end
         ST_RUN: begin
            pbits_in = {pbits_ff[IB-2:0], 1'b0};
            dbits_in = {dbits_ff[IB-2:0], 1'b0};
            pacc_in  = pacc_step;
            dacc_in  = dacc_step;
            povf_in  = povf_ff || (pacc_step > {1'b0, lim_ff});
            dovf_in  = dovf_ff || (dacc_step > {{(DW-OFFSET_BITS){1'b0}}, room_ff});
            num_in   = {num_ff[IB-2:0], 1'b0};
            rem_in   = div_ge ? SIZE_BITS'(div_trial - job_ff.stepmag)
                              : div_trial[SIZE_BITS-1:0];
            quo_in   = {quo_ff[IB-2:0], div_ge};
            if (cnt_ff == '0) begin
               state_in = ST_FIN;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_size_in   = fin_ok ? len : '0;
               out_stride_in = fin_ok ? stride_res : '0;
               out_offset_in = fin_ok ? offset_res : offset_ff;
               out_err_in    = err_final;
               out_failed_in = seen_ff || !fin_ok;
               out_last_in   = job_ff.last;
               if (fin_ok) begin
                  offset_in = offset_res;
               end
               seen_in  = seen_ff || !fin_ok;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         offset_ff    <= '0;
         seen_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         offset_ff    <= offset_in;
         seen_ff      <= seen_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff        <= job_reg_in;
      pbits_ff      <= pbits_in;
      dbits_ff      <= dbits_in;
      pacc_ff       <= pacc_in;
      dacc_ff       <= dacc_in;
      povf_ff       <= povf_in;
      dovf_ff       <= dovf_in;
      num_ff        <= num_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      lim_ff        <= lim_in;
      room_ff       <= room_in;
      out_size_ff   <= out_size_in;
      out_stride_ff <= out_stride_in;
      out_offset_ff <= out_offset_in;
      out_err_ff    <= out_err_in;
      out_failed_ff <= out_failed_in;
      out_last_ff   <= out_last_in;
   end

endmodule

// ----- src/tensor_slice_view_descriptor.sv -----
// Top level of the tensor slice view descriptor: stream ports, front end, queue and back end.
`timescale 1ns / 1ps

// Takes one tensor dimension per word and returns its sliced size and stride together with the
// running base offset of the view; first_dim (tuser bit 0) reloads the offset and clears the
// sticky failure flag, and tlast marks the last dimension. A word is registered into the front
// end, which applies slice defaults, wraps negative indices and checks step, bounds and order;
// a two-word queue then feeds the back end. The back end loads a dimension, steps its two
// shift-and-add multipliers and its radix-2 divider once per bit of the multiplier, and then
// finishes, holding there until the output is free; it takes no new dimension until it has
// finished the last one. A dimension rejected by the front end's checks goes from load straight
// to finish. Unsliced dimensions go through the same arithmetic path with a step of one.
module tensor_slice_view_descriptor #(
   parameter int SIZE_BITS   = tsv_pkg::SIZE_BITS_DEF,
   parameter int STRIDE_BITS = tsv_pkg::STRIDE_BITS_DEF,
   parameter int OFFSET_BITS = tsv_pkg::OFFSET_BITS_DEF,
   localparam int REQ_BITS   = OFFSET_BITS + SIZE_BITS + STRIDE_BITS + 3 * (SIZE_BITS + 1),
   localparam int REQ_W      = ((REQ_BITS + 7) / 8) * 8,
   localparam int RSP_BITS   = SIZE_BITS + STRIDE_BITS + OFFSET_BITS + 4,
   localparam int RSP_W      = ((RSP_BITS + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // base_offset, dim_size, dim_stride, start_index, end_index, step_value
   input  logic [REQ_W-1:0] req_tdata,
   // first_dim, has_slice, start_given, end_given, step_given
   input  logic [4:0]       req_tuser,
   input  logic             req_tlast,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // new_size, view_stride, view_offset, error_code, view_failed
   output logic [RSP_W-1:0] rsp_tdata,
   output logic             rsp_tlast
);
   import tsv_pkg::*;

   localparam int IB      = SIZE_BITS + 1;
   localparam int DIM_LO  = OFFSET_BITS;
   localparam int STR_LO  = DIM_LO + SIZE_BITS;
   localparam int SI_LO   = STR_LO + STRIDE_BITS;
   localparam int EI_LO   = SI_LO + IB;
   localparam int SV_LO   = EI_LO + IB;

   typedef struct packed {
      logic                   first;
      logic                   last;
      logic [OFFSET_BITS-1:0] base;
      err_code_type           err;
      logic                   sneg;
      logic                   pneg;
      logic [STRIDE_BITS-1:0] smag;
      logic [IB-1:0]          stepmag;
      logic [SIZE_BITS-1:0]   st;
      logic [SIZE_BITS-1:0]   span;
   } job_type;

   job_type                front_job;
   logic                   front_valid;
   logic                   front_ready;
   job_type                back_job;
   logic                   back_valid;
   logic                   back_ready;

   logic [SIZE_BITS-1:0]   new_size;
   logic [STRIDE_BITS-1:0] view_stride;
   logic [OFFSET_BITS-1:0] view_offset;
   err_code_type           error_code;
   logic                   view_failed;

   tsv_front #(
      .SIZE_BITS   (SIZE_BITS),
      .STRIDE_BITS (STRIDE_BITS),
      .OFFSET_BITS (OFFSET_BITS),
      .job_type    (job_type)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .first_dim   (req_tuser[0]),
      .last_dim    (req_tlast),
      .base_offset (req_tdata[OFFSET_BITS-1:0]),
      .dim_size    (req_tdata[DIM_LO +: SIZE_BITS]),
      .dim_stride  (req_tdata[STR_LO +: STRIDE_BITS]),
      .has_slice   (req_tuser[1]),
      .start_given (req_tuser[2]),
      .start_index (req_tdata[SI_LO +: IB]),
      .end_given   (req_tuser[3]),
      .end_index   (req_tdata[EI_LO +: IB]),
      .step_given  (req_tuser[4]),
      .step_value  (req_tdata[SV_LO +: IB]),
      .job_out     (front_job),
      .job_valid   (front_valid),
      .job_ready   (front_ready)
   );

   tsv_queue #(
      .job_type (job_type)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_job    (front_job),
      .out_valid (back_valid),
      .out_ready (back_ready),
      .out_job   (back_job)
   );

   tsv_back #(
      .SIZE_BITS   (SIZE_BITS),
      .STRIDE_BITS (STRIDE_BITS),
      .OFFSET_BITS (OFFSET_BITS),
      .job_type    (job_type)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .job_in      (back_job),
      .job_valid   (back_valid),
      .job_ready   (back_ready),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .new_size    (new_size),
      .view_stride (view_stride),
      .view_offset (view_offset),
      .error_code  (error_code),
      .view_failed (view_failed),
      .is_last     (rsp_tlast)
   );

   assign rsp_tdata = RSP_W'({view_failed, error_code, view_offset, view_stride, new_size});

endmodule
